@@ src/tpdq_pkg.sv @@
package tpdq_pkg;

  localparam int MAX_RESULTS = 32;
  localparam int KCW         = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    OP_ARM    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_ARMED    = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_EXPIRED  = 3'd3,
    ST_DONE     = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [47:0] now_time;
    logic [47:0] delay;
    logic [5:0]  slot_id;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot_no;
    logic [47:0] remaining;
    logic [6:0]  waiting_count;
    logic        last;
  } rsp_t;

endpackage

@@ src/tpdq_if.sv @@
interface tpdq_cmd_if;
  logic            valid;
  logic            ready;
  tpdq_pkg::cmd_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tpdq_rsp_if;
  logic            valid;
  logic            ready;
  tpdq_pkg::rsp_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/tpdq_ram.sv @@
module tpdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ src/timer_pool_deadline_queue.sv @@
// Pool of TIMER_SLOTS one-shot timers. Each command beat carries the current
// time; arm returns a slot and the time to expiry, cancel frees a slot, tick
// returns every due slot earliest first (ties lowest slot first, up to 32 per
// tick, last flagged), and query returns the time left to the earliest
// deadline. Live timers sit in a binary min-heap held in a simple dual-port RAM
// with registered read, walked one level at a time. The command port is not
// ready while a command runs. Arm sifts the new entry up the heap, query reads
// the root, cancel scans the heap linearly and then removes one entry, and
// tick removes one entry per expired timer. A finished result sits in an
// output register, so the next command is taken meanwhile.
module timer_pool_deadline_queue #(
  parameter int TIMER_SLOTS = 32,
  parameter int TIME_BITS   = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tpdq_cmd_if.sink    in_i,
  tpdq_rsp_if.source  out_o
);

  localparam int SW  = $clog2(TIMER_SLOTS);
  localparam int CW  = $clog2(TIMER_SLOTS + 1);
  localparam int PW  = SW + 2;
  localparam int TW  = TIME_BITS;
  localparam int KW  = TW + SW;
  localparam int KCW = tpdq_pkg::KCW;

  typedef enum logic [16:0] {
    S_IDLE     = 17'b00000000000000001,
    S_ARM      = 17'b00000000000000010,
    S_SCAN_RD  = 17'b00000000000000100,
    S_SCAN_CMP = 17'b00000000000001000,
    S_TICK_CHK = 17'b00000000000010000,
    S_TICK_USE = 17'b00000000000100000,
    S_Q_USE    = 17'b00000000001000000,
    S_RM       = 17'b00000000010000000,
    S_RM_LD    = 17'b00000000100000000,
    S_DN_L     = 17'b00000001000000000,
    S_DN_LC    = 17'b00000010000000000,
    S_DN_RC    = 17'b00000100000000000,
    S_DN_CMP   = 17'b00001000000000000,
    S_UP_RD    = 17'b00010000000000000,
    S_UP_CMP   = 17'b00100000000000000,
    S_AFTER    = 17'b01000000000000000,
    S_RESP     = 17'b10000000000000000
  } state_e;

  state_e                  state_q, state_d;
  tpdq_pkg::op_e           op_q, op_d;
  logic [TW-1:0]           now_q, now_d;
  logic [5:0]              sid_q, sid_d;
  logic [KW-1:0]           item_q, item_d;
  logic [KW-1:0]           best_q, best_d;
  logic [PW-1:0]           pos_q, pos_d;
  logic [PW-1:0]           start_q, start_d;
  logic [PW-1:0]           bpos_q, bpos_d;
  logic [CW-1:0]           len_q, len_d;
  logic [CW-1:0]           fc_q, fc_d;
  logic [CW-1:0]           lw_q, lw_d;
  logic [TIMER_SLOTS-1:0]  armed_q, armed_d;
  logic [KCW-1:0]          k_q, k_d;
  tpdq_pkg::status_e       rst_q, rst_d;
  logic [5:0]              rtid_q, rtid_d;
  logic [47:0]             rrem_q, rrem_d;
  logic [6:0]              rcnt_q, rcnt_d;
  logic                    rlast_q, rlast_d;
  logic                    ov_q, ov_d;
  tpdq_pkg::rsp_t          od_q, od_d;

  logic                    h_we;
  logic [SW-1:0]           h_raddr;
  logic [KW-1:0]           h_wdata, h_rdata;
  logic                    s_we;
  logic [SW-1:0]           s_waddr, s_raddr, s_wdata, s_rdata;

  logic                    out_free, load;
  logic [PW-1:0]           l_pos, r_pos, parent, len_p;
  logic [CW-1:0]           top;
  logic [SW-1:0]           pop_slot;
  logic [TW:0]             sum;
  logic [TW-1:0]           dl_in, root_dl;

  tpdq_ram #(.WIDTH(KW), .DEPTH(TIMER_SLOTS)) u_heap (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (pos_q[SW-1:0]),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  tpdq_ram #(.WIDTH(SW), .DEPTH(TIMER_SLOTS)) u_free (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = ov_q;
  assign out_o.data  = od_q;
  assign out_free    = !ov_q || out_o.ready;

  assign l_pos    = {pos_q[PW-2:0], 1'b1};
  assign r_pos    = l_pos + PW'(1);
  assign parent   = (pos_q - PW'(1)) >> 1;
  assign len_p    = PW'(len_q);
  assign top      = fc_q - CW'(1);
  assign pop_slot = (top < lw_q) ? SW'(top) : s_rdata;
  assign sum      = {1'b0, TW'(in_i.data.now_time)} + {1'b0, TW'(in_i.data.delay)};
  assign dl_in    = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
  assign root_dl  = h_rdata[KW-1:SW];
  assign s_waddr  = SW'(fc_q);
  assign s_raddr  = SW'(top);
  assign s_wdata  = rtid_q[SW-1:0];

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    now_d   = now_q;
    sid_d   = sid_q;
    item_d  = item_q;
    best_d  = best_q;
    pos_d   = pos_q;
    start_d = start_q;
    bpos_d  = bpos_q;
    len_d   = len_q;
    fc_d    = fc_q;
    lw_d    = lw_q;
    armed_d = armed_q;
    k_d     = k_q;
    rst_d   = rst_q;
    rtid_d  = rtid_q;
    rrem_d  = rrem_q;
    rcnt_d  = rcnt_q;
    rlast_d = rlast_q;
    h_we    = 1'b0;
    h_wdata = item_q;
    h_raddr = '0;
    s_we    = 1'b0;
    load    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d    = tpdq_pkg::op_e'(in_i.data.op);
          now_d   = TW'(in_i.data.now_time);
          sid_d   = in_i.data.slot_id;
          rlast_d = 1'b1;
          rtid_d  = '0;
          rrem_d  = '0;
          rcnt_d  = 7'(len_q);
          unique case (tpdq_pkg::op_e'(in_i.data.op))
            tpdq_pkg::OP_ARM: begin
              if (fc_q == '0 || len_q >= CW'(TIMER_SLOTS)) begin
                rst_d   = tpdq_pkg::ST_NO_SPACE;
                state_d = S_RESP;
              end else begin
                item_d  = {dl_in, SW'(0)};
                state_d = S_ARM;
              end
            end
            tpdq_pkg::OP_CANCEL: begin
              rtid_d = in_i.data.slot_id;
              if (7'(in_i.data.slot_id) >= 7'(TIMER_SLOTS) ||
                  !armed_q[in_i.data.slot_id[SW-1:0]]) begin
                rst_d   = tpdq_pkg::ST_IGNORED;
                state_d = S_RESP;
              end else begin
                pos_d   = '0;
                state_d = S_SCAN_RD;
              end
            end
            tpdq_pkg::OP_TICK: begin
              k_d     = '0;
              state_d = S_TICK_CHK;
            end
            tpdq_pkg::OP_QUERY: begin
              if (len_q == '0) begin
                rst_d   = tpdq_pkg::ST_EMPTY;
                state_d = S_RESP;
              end else begin
                state_d = S_Q_USE;
              end
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_ARM: begin
        item_d            = {item_q[KW-1:SW], pop_slot};
        armed_d[pop_slot] = 1'b1;
        fc_d              = top;
        lw_d              = (top < lw_q) ? top : lw_q;
        rst_d             = tpdq_pkg::ST_ARMED;
        rtid_d            = 6'(pop_slot);
        rrem_d            = 48'(item_q[KW-1:SW] - now_q);
        rcnt_d            = 7'(len_q + CW'(1));
        pos_d             = len_p;
        len_d             = len_q + CW'(1);
        state_d           = S_UP_RD;
      end
      S_SCAN_RD: begin
        h_raddr = pos_q[SW-1:0];
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (h_rdata[SW-1:0] == sid_q[SW-1:0]) begin
          state_d = S_RM;
        end else begin
          pos_d   = pos_q + PW'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_TICK_CHK: begin
        if (k_q == KCW'(tpdq_pkg::MAX_RESULTS) || len_q == '0) begin
          if (k_q == '0) begin
            rst_d  = tpdq_pkg::ST_DONE;
            rtid_d = '0;
            rcnt_d = 7'(len_q);
          end
          rlast_d = 1'b1;
          state_d = S_RESP;
        end else begin
          state_d = S_TICK_USE;
        end
      end
      S_TICK_USE: begin
        if (root_dl > now_q) begin
          if (k_q == '0) begin
            rst_d  = tpdq_pkg::ST_DONE;
            rtid_d = '0;
            rcnt_d = 7'(len_q);
          end
          rlast_d = 1'b1;
          state_d = S_RESP;
        end else if (k_q == '0 || out_free) begin
          load    = (k_q != '0);
          rtid_d  = 6'(h_rdata[SW-1:0]);
          pos_d   = '0;
          state_d = S_RM;
        end
      end
      S_Q_USE: begin
        rst_d   = tpdq_pkg::ST_ARMED;
        rtid_d  = 6'(h_rdata[SW-1:0]);
        rrem_d  = (root_dl > now_q) ? 48'(root_dl - now_q) : '0;
        state_d = S_RESP;
      end
      S_RM: begin
        h_raddr = SW'(len_q - CW'(1));
        len_d   = len_q - CW'(1);
        state_d = S_RM_LD;
      end
      S_RM_LD: begin
        if (pos_q == len_p) begin
          state_d = S_AFTER;
        end else begin
          item_d  = h_rdata;
          start_d = pos_q;
          state_d = S_DN_L;
        end
      end
      S_DN_L: begin
        if (l_pos >= len_p) begin
          if (pos_q == start_q) begin
            state_d = S_UP_RD;
          end else begin
            h_we    = 1'b1;
            state_d = S_AFTER;
          end
        end else begin
          h_raddr = l_pos[SW-1:0];
          state_d = S_DN_LC;
        end
      end
      S_DN_LC: begin
        best_d = h_rdata;
        bpos_d = l_pos;
        if (r_pos < len_p) begin
          h_raddr = r_pos[SW-1:0];
          state_d = S_DN_RC;
        end else begin
          state_d = S_DN_CMP;
        end
      end
      S_DN_RC: begin
        if (h_rdata < best_q) begin
          best_d = h_rdata;
          bpos_d = r_pos;
        end
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (best_q < item_q) begin
          h_we    = 1'b1;
          h_wdata = best_q;
          pos_d   = bpos_q;
          state_d = S_DN_L;
        end else if (pos_q == start_q) begin
          state_d = S_UP_RD;
        end else begin
          h_we    = 1'b1;
          state_d = S_AFTER;
        end
      end
      S_UP_RD: begin
        if (pos_q == '0) begin
          h_we    = 1'b1;
          state_d = S_AFTER;
        end else begin
          h_raddr = parent[SW-1:0];
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (item_q < h_rdata) begin
          h_we    = 1'b1;
          h_wdata = h_rdata;
          pos_d   = parent;
          state_d = S_UP_RD;
        end else begin
          h_we    = 1'b1;
          state_d = S_AFTER;
        end
      end
      S_AFTER: begin
        state_d = S_RESP;
        if (op_q == tpdq_pkg::OP_CANCEL || op_q == tpdq_pkg::OP_TICK) begin
          armed_d[rtid_q[SW-1:0]] = 1'b0;
          if (fc_q < CW'(TIMER_SLOTS)) begin
            s_we = 1'b1;
            fc_d = fc_q + CW'(1);
          end
          rrem_d = '0;
          rcnt_d = 7'(len_q);
          if (op_q == tpdq_pkg::OP_TICK) begin
            rst_d   = tpdq_pkg::ST_EXPIRED;
            rlast_d = 1'b0;
            k_d     = k_q + KCW'(1);
            state_d = S_TICK_CHK;
          end else begin
            rst_d = tpdq_pkg::ST_DONE;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    od_d = od_q;
    if (out_o.ready) begin
      ov_d = 1'b0;
    end
    if (load) begin
      ov_d               = 1'b1;
      od_d.status        = rst_q;
      od_d.slot_no       = rtid_q;
      od_d.remaining     = rrem_q;
      od_d.waiting_count = rcnt_q;
      od_d.last          = rlast_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= tpdq_pkg::OP_ARM;
      len_q   <= '0;
      fc_q    <= CW'(TIMER_SLOTS);
      lw_q    <= CW'(TIMER_SLOTS);
      armed_q <= '0;
      k_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      len_q   <= len_d;
      fc_q    <= fc_d;
      lw_q    <= lw_d;
      armed_q <= armed_d;
      k_q     <= k_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q   <= now_d;
    sid_q   <= sid_d;
    item_q  <= item_d;
    best_q  <= best_d;
    pos_q   <= pos_d;
    start_q <= start_d;
    bpos_q  <= bpos_d;
    rst_q   <= rst_d;
    rtid_q  <= rtid_d;
    rrem_q  <= rrem_d;
    rcnt_q  <= rcnt_d;
    rlast_q <= rlast_d;
    od_q    <= od_d;
  end

endmodule
